>>> rtl/r64gc_pkg.sv
// ----------------------------------------------------------------------------
// r64gc_pkg
// Shared types, status codes and alphabet mapping for the radix-64 codec.
// ----------------------------------------------------------------------------
`default_nettype none

package r64gc_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  localparam logic [2:0] ENC_SYMS   = 3'd6;
  localparam logic [2:0] DEC_BYTES  = 3'd4;

  // One unit of work for the output side: cnt data results, then an
  // optional error result when err is not ST_OK.
  typedef struct packed {
    logic        enc;
    logic [31:0] word;
    logic [2:0]  cnt;
    logic [1:0]  err;
  } job_t;

  function automatic logic [7:0] sym_to_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h61 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h41 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2D;
    end else begin
      c = 8'h2B;
    end
    return c;
  endfunction

  // Bit 6 set marks a character outside the alphabet.
  function automatic logic [6:0] char_to_sym(input logic [7:0] c);
    logic [6:0] s;
    if (c inside {[8'h61:8'h7A]}) begin
      s = 7'(c - 8'h61);
    end else if (c inside {[8'h41:8'h5A]}) begin
      s = 7'(c - 8'h41 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      s = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2D) begin
      s = 7'd62;
    end else if (c == 8'h2B) begin
      s = 7'd63;
    end else begin
      s = 7'd64;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/r64gc_front.sv
// ----------------------------------------------------------------------------
// r64gc_front
// Accepts bytes or characters, tracks group and error state, issues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module r64gc_front
  import r64gc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [47:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_data,
  input  wire logic        in_last,
  output logic             in_ready,
  output logic             job_valid,
  output job_t             job,
  input  wire logic        job_ready
);

  logic        mode_r, mode_nxt;
  logic [35:0] word_r, word_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [47:0] br_r, br_nxt;
  logic        halted_r, halted_nxt;
  logic [1:0]  err_r, err_nxt;

  logic        accept;
  logic [1:0]  epos;
  logic [31:0] ew;
  logic [2:0]  dpos;
  logic [6:0]  sym;
  logic [5:0]  dsh;
  logic [35:0] dw;
  logic [2:0]  n;
  logic [47:0] br_after;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    mode_nxt   = mode_r;
    word_nxt   = word_r;
    count_nxt  = count_r;
    br_nxt     = br_r;
    halted_nxt = halted_r;
    err_nxt    = err_r;
    job_valid  = 1'b0;
    job        = '0;

    epos     = count_r[1:0];
    ew       = word_r[31:0] | (32'(in_data) << {2'd3 - epos, 3'b000});
    sym      = char_to_sym(in_data);
    dpos     = (count_r > 3'd5) ? 3'd0 : count_r;
    dsh      = 6'd30 - (6'(dpos) << 2) - (6'(dpos) << 1);
    dw       = word_r | (36'(sym[5:0]) << dsh);
    n        = 3'd0;
    br_after = br_r;

    if (accept) begin
      if (halted_r) begin
        job_valid = 1'b1;
        job.err   = err_r;
      end else if (!mode_r) begin
        if (epos == 2'd3 || in_last) begin
          job_valid = 1'b1;
          job.enc   = 1'b1;
          job.word  = ew;
          job.cnt   = ENC_SYMS;
          word_nxt  = '0;
          count_nxt = '0;
        end else begin
          word_nxt  = {4'b0000, ew};
          count_nxt = {1'b0, epos} + 3'd1;
        end
      end else if (br_r != '0) begin
        if (sym[6]) begin
          job_valid  = 1'b1;
          job.err    = ST_INVALID;
          halted_nxt = 1'b1;
          err_nxt    = ST_INVALID;
          word_nxt   = '0;
          count_nxt  = '0;
        end else begin
          if (dpos == 3'd5) begin
            n         = (br_r >= 48'd4) ? DEC_BYTES : br_r[2:0];
            br_after  = br_r - 48'(n);
            word_nxt  = '0;
            count_nxt = '0;
          end else begin
            word_nxt  = dw;
            count_nxt = dpos + 3'd1;
          end
          br_nxt   = br_after;
          job.word = dw[35:4];
          job.cnt  = n;
          if (in_last && br_after != '0) begin
            job_valid  = 1'b1;
            job.err    = ST_TRUNC;
            halted_nxt = 1'b1;
            err_nxt    = ST_TRUNC;
            word_nxt   = '0;
            count_nxt  = '0;
          end else if (n != 3'd0) begin
            job_valid = 1'b1;
          end
        end
      end
    end

    if (cfg_we) begin
      if (!cfg_index) begin
        mode_nxt  = cfg_wdata[0];
        word_nxt  = '0;
        count_nxt = '0;
      end else begin
        br_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      word_r   <= '0;
      count_r  <= '0;
      br_r     <= '0;
      halted_r <= 1'b0;
      err_r    <= ST_OK;
    end else begin
      mode_r   <= mode_nxt;
      word_r   <= word_nxt;
      count_r  <= count_nxt;
      br_r     <= br_nxt;
      halted_r <= halted_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/r64gc_fifo.sv
// ----------------------------------------------------------------------------
// r64gc_fifo
// Short job queue between the front and back sides.
// ----------------------------------------------------------------------------
`default_nettype none

module r64gc_fifo
  import r64gc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  input  job_t      wr_job,
  output logic      wr_ready,
  output logic      rd_valid,
  output job_t      rd_job,
  input  wire logic rd_pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/r64gc_back.sv
// ----------------------------------------------------------------------------
// r64gc_back
// Expands queued jobs into result transfers, one per cycle unless out_tready stalls the output, into a register.
// ----------------------------------------------------------------------------
`default_nettype none

module r64gc_back
  import r64gc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_valid,
  input  job_t             job,
  output logic             job_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  logic [2:0]  idx_r, idx_nxt;
  logic        vld_r, vld_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic        last_r, last_nxt;

  logic        load;
  logic [2:0]  total;
  logic        final_res;
  logic [5:0]  ssh;
  logic [35:0] sw;
  logic [31:0] bw;

  always_comb begin
    total     = job.cnt + ((job.err != ST_OK) ? 3'd1 : 3'd0);
    final_res = (idx_r == total - 3'd1);
    load      = job_valid && (!vld_r || out_tready);
    job_pop   = load && final_res;

    ssh = (6'(idx_r) << 2) + (6'(idx_r) << 1);
    sw  = {job.word, 4'b0000} << ssh;
    bw  = job.word << {idx_r, 3'b000};

    vld_nxt  = vld_r;
    data_nxt = data_r;
    stat_nxt = stat_r;
    last_nxt = last_r;
    idx_nxt  = idx_r;

    if (vld_r && out_tready) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt  = 1'b1;
      last_nxt = final_res;
      idx_nxt  = final_res ? 3'd0 : idx_r + 3'd1;
      if (idx_r < job.cnt) begin
        data_nxt = job.enc ? sym_to_char(sw[35:30]) : bw[31:24];
        stat_nxt = ST_OK;
      end else begin
        data_nxt = 8'h00;
        stat_nxt = job.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    stat_r <= stat_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = stat_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

>>> rtl/radix64_group_codec.sv
// ----------------------------------------------------------------------------
// radix64_group_codec
// Byte-to-text group codec, 64-symbol alphabet, with encode and decode modes.
//
// channel | direction | payload
// in_*    | slave     | tdata[7:0] byte or character, tlast end of stream
// out_*   | master    | tdata[7:0] symbol or byte, tuser[1:0] status, tlast
// cfg_*   | write     | index 0 decode_mode, index 1 payload_length
//
// The front side takes one item per cycle while the job queue has room.
// The back side registers one result per cycle unless out_tready stalls it;
// an encoded group yields six symbols there.
// An item's job is queued, then its first result is registered at the output.
// Reset is synchronous; out_tready low holds results and fills the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module radix64_group_codec
  import r64gc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [47:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // data_res
  output logic [1:0]       out_tuser,  // status
  output logic             out_tlast
);

  logic job_wr_valid, job_wr_ready;
  job_t job_wr;
  logic job_rd_valid, job_rd_pop;
  job_t job_rd;

  r64gc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .job_valid (job_wr_valid),
    .job       (job_wr),
    .job_ready (job_wr_ready)
  );

  r64gc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (job_wr_valid),
    .wr_job   (job_wr),
    .wr_ready (job_wr_ready),
    .rd_valid (job_rd_valid),
    .rd_job   (job_rd),
    .rd_pop   (job_rd_pop)
  );

  r64gc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_rd_valid),
    .job        (job_rd),
    .job_pop    (job_rd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> test/radix64_group_codec_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix64_group_codec_test
// Self-checking bench for the radix-64 group codec. A stimulus table covers
// encode groups of extreme bytes, short groups, a mode write with a partial
// group, decode with no payload due, and decode groups that end on the
// payload length. Random encode and decode runs follow, with random idle
// bursts on both channels and payload lengths from zero to the maximum. The
// run ends by driving the codec into its sticky error state. Every result
// transfer is checked against a bit-exact predictor of the codec.
// ----------------------------------------------------------------------------

module radix64_group_codec_test;
  import r64gc_pkg::*;

  localparam logic        REG_MODE      = 1'b0;
  localparam logic        REG_LENGTH    = 1'b1;
  localparam logic        MODE_ENCODE   = 1'b0;
  localparam logic        MODE_DECODE   = 1'b1;
  localparam logic [47:0] LENGTH_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam int          ITEM_TARGET   = 450;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          REPORT_LIMIT  = 40;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       run_last;
  } codec_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_SET_MODE, ROW_SET_LENGTH} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [47:0] arg;
    logic        last;
    logic        typed;
    logic [7:0]  exp_data;
    logic [1:0]  exp_status;
  } stim_row_t;

  localparam int NUM_ROWS = 31;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [47:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  string alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-+";

  // codec model state
  logic        mode_dec = MODE_ENCODE;
  logic [35:0] acc_word = '0;
  logic [2:0]  acc_count = '0;
  logic [47:0] bytes_left = '0;
  logic        halted_flag = 1'b0;

  codec_result_t pending_results[$];
  codec_result_t next_result;
  stim_row_t     stim_rows[NUM_ROWS];

  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int stall_pct = 0;
  int gap_pct = 0;
  bit quiet = 1'b0;

  radix64_group_codec i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] symbol_char(input logic [5:0] v);
    return alphabet[int'(v)];
  endfunction

  // bit 6 flags a character outside the alphabet
  function automatic logic [6:0] symbol_value(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (alphabet[i] == c) return 7'(i);
    end
    return 7'd64;
  endfunction

  function automatic logic [7:0] random_symbol_char();
    return symbol_char(6'($urandom_range(0, 63)));
  endfunction

  function automatic logic [7:0] random_invalid_char();
    logic [7:0] c;
    logic [6:0] s;
    do begin
      c = 8'($urandom_range(0, 255));
      s = symbol_value(c);
    end while (!s[6]);
    return c;
  endfunction

  function automatic void enter_halt(input logic [1:0] code);
    codec_result_t r;
    r = '{8'h00, code, 1'b1};
    pending_results.push_back(r);
    halted_flag = 1'b1;
    acc_word = 36'(code);
    acc_count = '0;
  endfunction

  function automatic void apply_reg(input logic idx, input logic [47:0] val);
    if (idx == REG_MODE) begin
      mode_dec = val[0];
      if (!halted_flag) acc_word = '0;
      acc_count = '0;
    end else begin
      bytes_left = val;
    end
  endfunction

  function automatic void codec_step(input logic [7:0] d, input logic l);
    codec_result_t batch[$];
    codec_result_t r;
    logic [2:0]  pos;
    logic [6:0]  sym;
    logic [35:0] w;
    if (halted_flag) begin
      r = '{8'h00, acc_word[1:0], 1'b1};
      pending_results.push_back(r);
      return;
    end
    if (mode_dec == MODE_ENCODE) begin
      pos = {1'b0, acc_count[1:0]};
      acc_word = acc_word | (36'(d) << (8 * (3 - int'(pos))));
      acc_count = pos + 3'd1;
      if (acc_count == 3'd4 || l) begin
        w = acc_word << 4;
        for (int i = 0; i < 6; i++) begin
          r.data = symbol_char(w[35 - 6 * i -: 6]);
          r.status = ST_OK;
          r.run_last = (i == 5);
          pending_results.push_back(r);
        end
        acc_word = '0;
        acc_count = '0;
      end
      return;
    end
    if (bytes_left == '0) return;
    sym = symbol_value(d);
    if (sym[6]) begin
      enter_halt(ST_INVALID);
      return;
    end
    pos = (acc_count > 3'd5) ? 3'd0 : acc_count;
    acc_word = acc_word | (36'(sym[5:0]) << (30 - 6 * int'(pos)));
    acc_count = pos + 3'd1;
    if (acc_count == 3'd6) begin
      w = acc_word >> 4;
      for (int i = 0; i < 4; i++) begin
        if (bytes_left != '0) begin
          r.data = w[31 - 8 * i -: 8];
          r.status = ST_OK;
          r.run_last = 1'b0;
          batch.push_back(r);
          bytes_left = bytes_left - 48'd1;
        end
      end
      acc_word = '0;
      acc_count = '0;
    end
    if (batch.size() > 0) begin
      r = batch.pop_back();
      r.run_last = !(l && bytes_left != '0);
      batch.push_back(r);
    end
    foreach (batch[i]) pending_results.push_back(batch[i]);
    if (l && bytes_left != '0) enter_halt(ST_TRUNC);
  endfunction

  task automatic send_item(input logic [7:0] d, input logic l);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    codec_step(d, l);
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [47:0] val);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        if (errors < REPORT_LIMIT)
          $display("%0t: unexpected result: data %02h status %0d last %0b",
                   $time, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        next_result = pending_results.pop_front();
        if (out_tdata !== next_result.data || out_tuser !== next_result.status ||
            out_tlast !== next_result.run_last) begin
          if (errors < REPORT_LIMIT)
            $display("%0t: mismatch: expected %02h/%0d/%0b, actual %02h/%0d/%0b",
                     $time, next_result.data, next_result.status, next_result.run_last,
                     out_tdata, out_tuser, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("radix64_group_codec_test NOT OK");
      $finish;
    end
  end

  initial begin
    stim_row_t     row;
    codec_result_t r;
    int            items_sent;
    int            phase;
    int            budget;
    int            n;
    int            err_kind;
    logic [47:0]   length;

    stim_rows = '{
      '{ROW_ITEM,       48'h00, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h00, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h00, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h00, 1'b0, 1'b1, 8'h61, ST_OK},
      '{ROW_ITEM,       48'hFF, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'hFF, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'hFF, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'hFF, 1'b0, 1'b1, 8'h57, ST_OK},
      '{ROW_ITEM,       48'h80, 1'b1, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h5A, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_SET_MODE,   48'(MODE_ENCODE), 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h3C, 1'b1, 1'b0, 8'h00, ST_OK},
      '{ROW_SET_MODE,   48'(MODE_DECODE), 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_SET_LENGTH, 48'd0,  1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h23, 1'b1, 1'b0, 8'h00, ST_OK},
      '{ROW_SET_LENGTH, 48'd5,  1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h2B, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h2B, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h2B, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h2B, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h2B, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h2B, 1'b0, 1'b1, 8'hFF, ST_OK},
      '{ROW_ITEM,       48'h5A, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h7A, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_SET_MODE,   48'(MODE_DECODE), 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h2D, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h2D, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h2D, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h2D, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h2D, 1'b0, 1'b0, 8'h00, ST_OK},
      '{ROW_ITEM,       48'h30, 1'b1, 1'b0, 8'h00, ST_OK}
    };

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    gap_pct = 30;
    stall_pct = 30;
    for (int k = 0; k < NUM_ROWS; k++) begin
      row = stim_rows[k];
      case (row.kind)
        ROW_SET_MODE: begin
          write_reg(REG_MODE, row.arg);
        end
        ROW_SET_LENGTH: begin
          write_reg(REG_LENGTH, row.arg);
        end
        default: begin
          send_item(row.arg[7:0], row.last);
          if (row.typed) begin
            r = pending_results.pop_back();
            r.data = row.exp_data;
            r.status = row.exp_status;
            pending_results.push_back(r);
          end
        end
      endcase
    end

    items_sent = 0;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 25;
        default: gap_pct = 60;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 60;
      endcase
      if (phase < 2 || $urandom_range(0, 1) == 1) begin
        if (phase == 0) begin
          length = LENGTH_MAX;
        end else if (phase == 1) begin
          length = '0;
        end else begin
          case ($urandom_range(0, 9))
            7: length = '0;
            8: length = LENGTH_MAX;
            9: length = {16'($urandom), 32'($urandom)};
            default: length = 48'($urandom_range(1, 24));
          endcase
        end
        write_reg(REG_MODE, 48'(MODE_DECODE));
        write_reg(REG_LENGTH, length);
        budget = $urandom_range(12, 48);
        while (bytes_left != '0 && budget > 0) begin
          send_item(random_symbol_char(),
                    (acc_count == 3'd5 && bytes_left <= 48'd4) ?
                      1'($urandom_range(0, 1)) : 1'b0);
          items_sent++;
          budget--;
        end
        if (bytes_left == '0) begin
          repeat ($urandom_range(0, 8)) begin
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            items_sent++;
          end
        end
      end else begin
        write_reg(REG_MODE, 48'(MODE_ENCODE));
        repeat ($urandom_range(8, 40)) begin
          send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
          items_sent++;
        end
      end
      phase++;
    end

    // error and halted behavior, no idling from here on
    quiet = 1'b1;
    write_reg(REG_MODE, 48'(MODE_DECODE));
    write_reg(REG_LENGTH, 48'($urandom_range(5, 12)));
    err_kind = $urandom_range(0, 2);
    if (err_kind == 2) begin
      n = $urandom_range(1, 11);
      for (int k = 1; k <= n; k++) send_item(random_symbol_char(), k == n);
    end else begin
      repeat ($urandom_range(0, 5)) send_item(random_symbol_char(), 1'b0);
      send_item(random_invalid_char(), err_kind == 1);
    end
    repeat (4) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    write_reg(REG_MODE, 48'(MODE_ENCODE));
    repeat (4) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    settle();

    if (errors == 0) begin
      $display("radix64_group_codec_test OK");
    end else begin
      $display("radix64_group_codec_test NOT OK");
    end
    $finish;
  end

endmodule
